/* design/tcrd_pkg.sv */
// Shared types, codes and default sizes for the card record deframer.
// Used by every module of the block; depends on nothing.
package tcrd_pkg;

  // Default sizes of the card store.
  localparam int CARD_SLOTS_DEF      = 16;
  localparam int NAME_BYTES_DEF      = 32;
  localparam int LAST_FOUR_BYTES_DEF = 5;
  localparam int PAN_BYTES_DEF       = 64;
  localparam int CVV_BYTES_DEF       = 16;
  localparam int EXPIRY_BYTES_DEF    = 16;

  // Fixed widths of command fields, the staging size and the queue depth.
  localparam int SLOT_W      = 6;
  localparam int CARDS_W     = 7;
  localparam int STAGE_BYTES = 64;
  localparam int QDEPTH      = 4;

  // Input actions.
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_SYNC = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // Packet flags.
  localparam logic [7:0] FLAG_CLEAR     = 8'h01;
  localparam logic [7:0] FLAG_STOP      = 8'h02;
  localparam logic [7:0] FLAG_LAST_FOUR = 8'h03;
  localparam logic [7:0] FLAG_FIRST     = 8'h04;
  localparam logic [7:0] FLAG_LAST      = 8'h05;
  localparam logic [7:0] FLAG_PAN_A     = 8'h06;
  localparam logic [7:0] FLAG_PAN_B     = 8'h07;
  localparam logic [7:0] FLAG_CVV_A     = 8'h08;
  localparam logic [7:0] FLAG_CVV_B     = 8'h09;
  localparam logic [7:0] FLAG_EXP_A     = 8'h0A;
  localparam logic [7:0] FLAG_EXP_B     = 8'h0B;

  // Field codes, in the order of field_select.
  localparam logic [2:0] FLD_FIRST     = 3'd0;
  localparam logic [2:0] FLD_LAST      = 3'd1;
  localparam logic [2:0] FLD_LAST_FOUR = 3'd2;
  localparam logic [2:0] FLD_PAN       = 3'd3;
  localparam logic [2:0] FLD_CVV       = 3'd4;
  localparam logic [2:0] FLD_EXPIRY    = 3'd5;
  localparam int         FIELDS        = 6;

  typedef enum logic [1:0] {
    PH_FLAG, PH_LEN, PH_DATA, PH_CHK
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_STAGE, OP_CLEAR, OP_MARK, OP_WRITE, OP_READ
  } op_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DISP, B_CLR, B_LRD, B_LWT, B_CPR, B_CPW, B_RD1, B_RD2, B_EMIT
  } bstate_t;

  // One command from the parser to the store engine, with its status.
  typedef struct packed {
    op_t                 op;
    logic                append;
    logic [2:0]          field;
    logic [SLOT_W-1:0]   slot;
    logic [7:0]          plen;
    logic [7:0]          data;
    logic [5:0]          addr;
    logic [3:0]          card_sel;
    logic                done;
    logic                good;
    logic [7:0]          kind;
    logic [CARDS_W-1:0]  cards;
    logic                full;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  read_byte;
    logic [6:0]  read_length;
    logic        read_card_valid;
    logic        packet_done;
    logic        checksum_good;
    logic [7:0]  packet_kind;
    logic [4:0]  cards_filled;
    logic        store_full;
  } rslt_t;

endpackage

/* design/tcrd_front.sv */
// Parser front end: accepts input items, tracks the packet framing and
// turns each item into one store command. Depends on tcrd_pkg.
module tcrd_front #(
  parameter int CARD_SLOTS = tcrd_pkg::CARD_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [1:0]        action,
  input  logic [7:0]        rx_byte,
  input  logic [3:0]        card_select,
  input  logic [2:0]        field_select,
  input  logic [5:0]        byte_offset,
  output tcrd_pkg::cmd_t    cmd
);
  import tcrd_pkg::*;

  localparam int CIW = $clog2(CARD_SLOTS + 1);

  phase_t         phase, phase_next;
  logic [7:0]     flag, flag_next;
  logic [7:0]     plen, plen_next;
  logic [7:0]     cnt, cnt_next;
  logic [7:0]     xsum, xsum_next;
  logic [CIW-1:0] card_index, card_index_next;
  logic           ci_full;

  assign ci_full = (32'(card_index) >= CARD_SLOTS);

  // Framing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FLAG;
      flag       <= '0;
      plen       <= '0;
      cnt        <= '0;
      xsum       <= '0;
      card_index <= '0;
    end else if (take) begin
      phase      <= phase_next;
      flag       <= flag_next;
      plen       <= plen_next;
      cnt        <= cnt_next;
      xsum       <= xsum_next;
      card_index <= card_index_next;
    end
  end

  // Next framing state and the command for this item.
  always_comb begin
    phase_next      = phase;
    flag_next       = flag;
    plen_next       = plen;
    cnt_next        = cnt;
    xsum_next       = xsum;
    card_index_next = card_index;
    cmd             = '0;
    cmd.op          = OP_NONE;
    cmd.slot        = SLOT_W'(card_index);
    cmd.plen        = plen;
    unique case (action)
      ACT_BYTE: begin
        if (!ci_full) begin
          unique case (phase)
            PH_FLAG: begin
              flag_next  = rx_byte;
              xsum_next  = rx_byte;
              phase_next = PH_LEN;
            end
            PH_LEN: begin
              plen_next  = rx_byte;
              xsum_next  = xsum ^ rx_byte;
              cnt_next   = '0;
              phase_next = (rx_byte == 8'd0) ? PH_CHK : PH_DATA;
            end
            PH_DATA: begin
              if (cnt < 8'(STAGE_BYTES)) begin
                cmd.op   = OP_STAGE;
                cmd.addr = cnt[5:0];
                cmd.data = rx_byte;
              end
              xsum_next = xsum ^ rx_byte;
              cnt_next  = cnt + 8'd1;
              if (cnt + 8'd1 >= plen) phase_next = PH_CHK;
            end
            PH_CHK: begin
              cmd.done   = 1'b1;
              cmd.kind   = flag;
              cmd.good   = (xsum == rx_byte);
              phase_next = PH_FLAG;
              if (xsum == rx_byte) begin
                unique case (flag) inside
                  FLAG_CLEAR: cmd.op = OP_CLEAR;
                  FLAG_STOP: begin
                    cmd.op          = OP_MARK;
                    card_index_next = card_index + CIW'(1);
                  end
                  FLAG_LAST_FOUR: begin
                    cmd.op    = OP_WRITE;
                    cmd.field = FLD_LAST_FOUR;
                  end
                  FLAG_FIRST: begin
                    cmd.op    = OP_WRITE;
                    cmd.field = FLD_FIRST;
                  end
                  FLAG_LAST: begin
                    cmd.op    = OP_WRITE;
                    cmd.field = FLD_LAST;
                  end
                  FLAG_PAN_A, FLAG_PAN_B: begin
                    cmd.op     = OP_WRITE;
                    cmd.append = 1'b1;
                    cmd.field  = FLD_PAN;
                  end
                  FLAG_CVV_A, FLAG_CVV_B: begin
                    cmd.op     = OP_WRITE;
                    cmd.append = 1'b1;
                    cmd.field  = FLD_CVV;
                  end
                  FLAG_EXP_A, FLAG_EXP_B: begin
                    cmd.op     = OP_WRITE;
                    cmd.append = 1'b1;
                    cmd.field  = FLD_EXPIRY;
                  end
                  default: cmd.op = OP_NONE;
                endcase
              end
            end
            default: phase_next = PH_FLAG;
          endcase
        end
      end
      ACT_SYNC: begin
        phase_next      = PH_FLAG;
        card_index_next = '0;
        cnt_next        = '0;
        xsum_next       = '0;
      end
      ACT_READ: begin
        cmd.op       = OP_READ;
        cmd.card_sel = card_select;
        cmd.field    = field_select;
        cmd.addr     = byte_offset;
      end
      default: cmd.op = OP_NONE;
    endcase
    cmd.cards = CARDS_W'(card_index_next);
    cmd.full  = (32'(card_index_next) >= CARD_SLOTS);
  end

endmodule

/* design/tcrd_queue.sv */
// Short command queue between the parser and the store engine.
// Depends on tcrd_pkg.
module tcrd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcrd_pkg::cmd_t  wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output tcrd_pkg::cmd_t  rdata
);
  import tcrd_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t          slots [QDEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wdata;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PW'(1);
      if (pop)  rptr <= rptr + PW'(1);
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

/* design/tcrd_back.sv */
// Store engine: executes queued commands against the staging buffer, the
// length table and the card byte store, and holds the result register.
// Depends on tcrd_pkg.
module tcrd_back #(
  parameter int CARD_SLOTS      = tcrd_pkg::CARD_SLOTS_DEF,
  parameter int NAME_BYTES      = tcrd_pkg::NAME_BYTES_DEF,
  parameter int LAST_FOUR_BYTES = tcrd_pkg::LAST_FOUR_BYTES_DEF,
  parameter int PAN_BYTES       = tcrd_pkg::PAN_BYTES_DEF,
  parameter int CVV_BYTES       = tcrd_pkg::CVV_BYTES_DEF,
  parameter int EXPIRY_BYTES    = tcrd_pkg::EXPIRY_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  tcrd_pkg::cmd_t  head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output tcrd_pkg::rslt_t rslt
);
  import tcrd_pkg::*;

  localparam int REC  = 2*NAME_BYTES + LAST_FOUR_BYTES + PAN_BYTES + CVV_BYTES
                        + EXPIRY_BYTES;
  localparam int DMEM = CARD_SLOTS * REC;
  localparam int LMEM = CARD_SLOTS * FIELDS;
  localparam int DAW  = $clog2(DMEM);
  localparam int LAW  = $clog2(LMEM);
  localparam int SW   = (CARD_SLOTS > 1) ? $clog2(CARD_SLOTS) : 1;

  bstate_t    state, state_next;
  cmd_t       cur;
  logic [2:0] clr_cnt;
  logic [6:0] n_q, start_q, idx;

  logic [7:0] stage_mem [STAGE_BYTES];
  logic [6:0] len_mem [LMEM];
  logic [7:0] data_mem [DMEM];
  logic [7:0] stage_q, data_q;
  logic [6:0] len_q;
  logic       row_vld [CARD_SLOTS];
  logic       card_vld [CARD_SLOTS];

  logic [7:0] rd_byte;
  logic [6:0] rd_len;
  logic       rd_valid;

  logic [SW-1:0]  wslot, rslot;
  logic           cs_ok, fs_ok;
  logic [15:0]    capf, basef;
  logic [15:0]    lw_addr, lr_addr_full, dw_full, dr_full;
  logic [7:0]     room, n_calc, start_calc;
  logic           lm_we, lm_re, dm_we, dm_re, st_we, st_re;
  logic [6:0]     lm_wd;
  logic           emit;

  assign wslot = cur.slot[SW-1:0];
  assign rslot = SW'(cur.card_sel);
  assign cs_ok = (32'(cur.card_sel) < CARD_SLOTS);
  assign fs_ok = (cur.field < 3'(FIELDS));

  // Capacity and byte base of the current field within a card record.
  always_comb begin
    case (cur.field)
      FLD_FIRST:     begin capf = 16'(NAME_BYTES);      basef = 16'd0; end
      FLD_LAST:      begin capf = 16'(NAME_BYTES);      basef = 16'(NAME_BYTES); end
      FLD_LAST_FOUR: begin capf = 16'(LAST_FOUR_BYTES); basef = 16'(2*NAME_BYTES); end
      FLD_PAN: begin
        capf  = 16'(PAN_BYTES);
        basef = 16'(2*NAME_BYTES + LAST_FOUR_BYTES);
      end
      FLD_CVV: begin
        capf  = 16'(CVV_BYTES);
        basef = 16'(2*NAME_BYTES + LAST_FOUR_BYTES + PAN_BYTES);
      end
      FLD_EXPIRY: begin
        capf  = 16'(EXPIRY_BYTES);
        basef = 16'(2*NAME_BYTES + LAST_FOUR_BYTES + PAN_BYTES + CVV_BYTES);
      end
      default: begin capf = 16'd0; basef = 16'd0; end
    endcase
  end

  // Copy length and start offset for an overwrite or an append.
  always_comb begin
    room = (16'(len_q) < capf) ? 8'(capf - 16'(len_q)) : 8'd0;
    if (cur.append) begin
      n_calc     = (cur.plen < room) ? cur.plen : room;
      start_calc = 8'(len_q);
    end else begin
      n_calc     = (16'(cur.plen) < capf - 16'd1) ? cur.plen : 8'(capf - 16'd1);
      start_calc = 8'd0;
    end
  end

  // Memory addresses.
  always_comb begin
    lw_addr      = 16'(cur.slot) * 16'(FIELDS)
                   + ((state == B_CLR) ? 16'(clr_cnt) : 16'(cur.field));
    lr_addr_full = (state == B_RD1)
                   ? ((cs_ok && fs_ok) ? 16'(cur.card_sel) * 16'(FIELDS) + 16'(cur.field)
                                       : 16'd0)
                   : 16'(cur.slot) * 16'(FIELDS) + 16'(cur.field);
    dw_full      = 16'(cur.slot) * 16'(REC) + basef + 16'(start_q) + 16'(idx);
    dr_full      = 16'(cur.card_sel) * 16'(REC) + basef + 16'(cur.addr);
    if (dr_full >= 16'(DMEM)) dr_full = 16'd0;
  end

  // Sequencer: next state and memory strobes.
  always_comb begin
    state_next = state;
    pop   = 1'b0;
    lm_we = 1'b0;
    lm_re = 1'b0;
    lm_wd = '0;
    dm_we = 1'b0;
    dm_re = 1'b0;
    st_we = 1'b0;
    st_re = 1'b0;
    emit  = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = B_DISP;
        end
      end
      B_DISP: begin
        unique case (cur.op)
          OP_STAGE: begin
            st_we      = 1'b1;
            state_next = B_EMIT;
          end
          OP_CLEAR: state_next = B_CLR;
          OP_WRITE: state_next = row_vld[wslot] ? B_LRD : B_CLR;
          OP_READ:  state_next = B_RD1;
          default:  state_next = B_EMIT;
        endcase
      end
      B_CLR: begin
        lm_we = 1'b1;
        if (clr_cnt == 3'(FIELDS - 1))
          state_next = (cur.op == OP_WRITE) ? B_LRD : B_EMIT;
      end
      B_LRD: begin
        lm_re      = 1'b1;
        state_next = B_LWT;
      end
      B_LWT: begin
        lm_we      = 1'b1;
        lm_wd      = 7'(start_calc + n_calc);
        state_next = (n_calc == 8'd0) ? B_EMIT : B_CPR;
      end
      B_CPR: begin
        st_re      = 1'b1;
        state_next = B_CPW;
      end
      B_CPW: begin
        dm_we      = 1'b1;
        state_next = (idx + 7'd1 == n_q) ? B_EMIT : B_CPR;
      end
      B_RD1: begin
        lm_re      = 1'b1;
        dm_re      = 1'b1;
        state_next = B_RD2;
      end
      B_RD2: state_next = B_EMIT;
      B_EMIT: begin
        if (!out_valid || !out_stall) begin
          emit       = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // Staging buffer, length table and byte store.
  always_ff @(posedge clk) begin
    if (st_we) stage_mem[cur.addr] <= cur.data;
    if (st_re) stage_q <= stage_mem[idx[5:0]];
    if (lm_we) len_mem[lw_addr[LAW-1:0]] <= lm_wd;
    if (lm_re) len_q <= len_mem[lr_addr_full[LAW-1:0]];
    if (dm_we) data_mem[dw_full[DAW-1:0]] <= stage_q;
    if (dm_re) data_q <= data_mem[dr_full[DAW-1:0]];
  end

  // Row-initialized and card-closed marks.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CARD_SLOTS; i++) begin
        row_vld[i]  <= 1'b0;
        card_vld[i] <= 1'b0;
      end
    end else begin
      if (state == B_DISP && cur.op == OP_CLEAR) card_vld[wslot] <= 1'b0;
      if (state == B_DISP && cur.op == OP_MARK)  card_vld[wslot] <= 1'b1;
      if (state == B_CLR && clr_cnt == 3'(FIELDS - 1)) row_vld[wslot] <= 1'b1;
    end
  end

  // Current command, counters and read results.
  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (state == B_DISP) clr_cnt <= '0;
    else if (state == B_CLR) clr_cnt <= clr_cnt + 3'd1;
    if (state == B_LWT) begin
      n_q     <= 7'(n_calc);
      start_q <= 7'(start_calc);
      idx     <= '0;
    end else if (state == B_CPW) begin
      idx <= idx + 7'd1;
    end
    if (state == B_RD2) begin
      if (cs_ok && fs_ok && row_vld[rslot]) begin
        rd_len  <= len_q;
        rd_byte <= (7'(cur.addr) < len_q) ? data_q : 8'd0;
      end else begin
        rd_len  <= '0;
        rd_byte <= '0;
      end
      rd_valid <= cs_ok && fs_ok && card_vld[rslot];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      rslt.read_byte       <= (cur.op == OP_READ) ? rd_byte : 8'd0;
      rslt.read_length     <= (cur.op == OP_READ) ? rd_len : 7'd0;
      rslt.read_card_valid <= (cur.op == OP_READ) && rd_valid;
      rslt.packet_done     <= cur.done;
      rslt.checksum_good   <= cur.good;
      rslt.packet_kind     <= cur.kind;
      rslt.cards_filled    <= 5'(cur.cards);
      rslt.store_full      <= cur.full;
    end
  end

endmodule

/* design/tlv_card_record_deframer.sv */
// Top level of the card record deframer: parser, command queue, store engine.
// Depends on tcrd_pkg, tcrd_front, tcrd_queue and tcrd_back.
//
//   Channel   Signals                                          Direction
//   input     in_valid, in_stall, action, rx_byte,             in (stall out)
//             card_select, field_select, byte_offset
//   result    out_valid, out_stall, read_byte, read_length,    out (stall in)
//             read_card_valid, packet_done, checksum_good,
//             packet_kind, cards_filled, store_full
//
// The parser takes an item whenever the four-entry queue has room. The store
// engine handles one queued command at a time; a committed field write copies
// n bytes (n up to 64, one staging read and one store write per byte), after
// zeroing the slot's length row if it was not yet initialized. Reset is
// synchronous; no clearing pass is needed.
// A stalled result holds the engine, and the queue then fills and stalls input.
module tlv_card_record_deframer #(
  parameter int CARD_SLOTS      = tcrd_pkg::CARD_SLOTS_DEF,
  parameter int NAME_BYTES      = tcrd_pkg::NAME_BYTES_DEF,
  parameter int LAST_FOUR_BYTES = tcrd_pkg::LAST_FOUR_BYTES_DEF,
  parameter int PAN_BYTES       = tcrd_pkg::PAN_BYTES_DEF,
  parameter int CVV_BYTES       = tcrd_pkg::CVV_BYTES_DEF,
  parameter int EXPIRY_BYTES    = tcrd_pkg::EXPIRY_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] rx_byte,
  input  logic [3:0] card_select,
  input  logic [2:0] field_select,
  input  logic [5:0] byte_offset,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_byte,
  output logic [6:0] read_length,
  output logic       read_card_valid,
  output logic       packet_done,
  output logic       checksum_good,
  output logic [7:0] packet_kind,
  output logic [4:0] cards_filled,
  output logic       store_full
);
  import tcrd_pkg::*;

  cmd_t  cmd_in, cmd_head;
  rslt_t rslt;
  logic  q_full, q_empty, q_pop, take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  tcrd_front #(.CARD_SLOTS(CARD_SLOTS)) u_front (
    .clk, .rst, .take, .action, .rx_byte, .card_select, .field_select,
    .byte_offset, .cmd(cmd_in)
  );

  tcrd_queue u_queue (
    .clk, .rst, .push(take), .wdata(cmd_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(cmd_head)
  );

  tcrd_back #(
    .CARD_SLOTS(CARD_SLOTS), .NAME_BYTES(NAME_BYTES),
    .LAST_FOUR_BYTES(LAST_FOUR_BYTES), .PAN_BYTES(PAN_BYTES),
    .CVV_BYTES(CVV_BYTES), .EXPIRY_BYTES(EXPIRY_BYTES)
  ) u_back (
    .clk, .rst, .empty(q_empty), .head(cmd_head), .pop(q_pop),
    .out_valid, .out_stall, .rslt
  );

  assign read_byte       = rslt.read_byte;
  assign read_length     = rslt.read_length;
  assign read_card_valid = rslt.read_card_valid;
  assign packet_done     = rslt.packet_done;
  assign checksum_good   = rslt.checksum_good;
  assign packet_kind     = rslt.packet_kind;
  assign cards_filled    = rslt.cards_filled;
  assign store_full      = rslt.store_full;

  // A result without a completed packet carries no packet status.
  a_no_packet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !packet_done |-> !checksum_good && packet_kind == 8'd0)
    else $error("packet status without a completed packet");

  // Packet results and read results never mix.
  a_packet_no_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_done |-> read_length == 7'd0 && read_byte == 8'd0)
    else $error("read data on a packet result");

  // A stored field never exceeds the staging size.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> read_length <= 7'(STAGE_BYTES))
    else $error("field length out of range");

endmodule
